>>> hdl/ert_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and constants of the ellipse ring tessellator.
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int P_MAX_SEGMENTS = 64;
    localparam int P_PHASE_BITS   = 16;

    // pi/2 in Q32, split for two narrow multiplies
    localparam logic [15:0] PI_HALF_LO = 16'hB544;
    localparam logic [16:0] PI_HALF_HI = 17'h1921F;

    localparam logic [33:0] ONE_Q29   = 34'h0_2000_0000;
    localparam int          SIN_TERMS = 7;
    localparam int          COS_TERMS = 8;

    // classified request, radii as sign and magnitude
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [31:0]        in_x_mag;
        logic               in_x_neg;
        logic [31:0]        in_y_mag;
        logic               in_y_neg;
        logic [31:0]        out_x_mag;
        logic [31:0]        out_y_mag;
        logic [6:0]         nseg;
    } t_req;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_SEG,
        BK_XLO,
        BK_XHI,
        BK_XSQ,
        BK_XSQR,
        BK_TMUL,
        BK_TRND,
        BK_TRCP,
        BK_TQ,
        BK_TACC,
        BK_FOLD,
        BK_PMUL,
        BK_PRND,
        BK_EMIT
    } t_bk_state;

endpackage

>>> hdl/ert_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_if
// Handshake channels of the tessellator: request in, segment out.
// ----------------------------------------------------------------------------
interface ert_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic [6:0]         segment_count;
    logic [30:0]        stroke_width;

    modport source (
        output valid, center_x, center_y, radius_x, radius_y, segment_count, stroke_width,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, radius_x, radius_y, segment_count, stroke_width,
        output ready
    );
endinterface

interface ert_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inner_x;
    logic signed [31:0] inner_y;
    logic signed [31:0] outer_x;
    logic signed [31:0] outer_y;
    logic [6:0]         inner_here_index;
    logic [6:0]         outer_here_index;
    logic [6:0]         inner_next_index;
    logic [6:0]         outer_next_index;
    logic               last_segment;

    modport source (
        output valid, inner_x, inner_y, outer_x, outer_y, inner_here_index,
               outer_here_index, inner_next_index, outer_next_index, last_segment,
        input  ready
    );
    modport sink (
        input  valid, inner_x, inner_y, outer_x, outer_y, inner_here_index,
               outer_here_index, inner_next_index, outer_next_index, last_segment,
        output ready
    );
endinterface

>>> hdl/ellipse_ring_tessellator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_ring_tessellator_top
// Outline ring of an ellipse: one request in, one vertex pair per segment out.
// ----------------------------------------------------------------------------
// Usage:
//   i_req takes one request (centre, radii, segment count, stroke width);
//   o_seg gives one item per segment in order, last_segment on the final one.
//   Both channels move an item when valid and ready are high at a clock edge.
//   A request with a segment count of zero is taken and gives nothing.
//   A request first sets up its phase step by dividing 2^PHASE_BITS by its
//   segment count, then its segments are worked out one after another. Each
//   segment runs the sine and cosine series and the four vertex products
//   through one shared 32x32 multiplier.
//   Two requests can wait in the queue behind the one in progress, and one
//   more in the input stage.
//   If o_seg stalls, the finished segment holds in the output register and
//   the sequencer waits; the front keeps accepting until the queue and its input stage are full.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any request
//   in progress.
// ----------------------------------------------------------------------------
module ellipse_ring_tessellator_top #(
    parameter int MAX_SEGMENTS = ert_pkg::P_MAX_SEGMENTS,
    parameter int PHASE_BITS   = ert_pkg::P_PHASE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ert_req_if.sink   i_req,
    ert_seg_if.source o_seg
);
    import ert_pkg::*;

    logic w_push_valid;
    logic w_push_ready;
    t_req w_push_req;
    logic w_pop_valid;
    logic w_pop_ready;
    t_req w_pop_req;

    ert_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_req   (w_push_req)
    );

    ert_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_req   (w_push_req),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_req    (w_pop_req)
    );

    ert_back #(
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_req   (w_pop_req),
        .o_seg       (o_seg)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_seg.valid)
        else $error("output valid after reset");

    a_no_empty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_ready) |-> (w_push_req.nseg != 7'd0))
        else $error("empty request queued");

    a_count_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_ready) |-> (w_push_req.nseg <= 7'(MAX_SEGMENTS)))
        else $error("segment count not clamped");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && o_seg.last_segment) |->
        (o_seg.inner_next_index == 7'd0 && o_seg.outer_next_index == 7'd1))
        else $error("last segment indices do not wrap");
`endif

endmodule

>>> hdl/ert_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_front
// Accepts requests, drops empty ones, clamps the segment count and forms
// the inner and outer radii.
// ----------------------------------------------------------------------------
module ert_front #(
    parameter int MAX_SEGMENTS = ert_pkg::P_MAX_SEGMENTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ert_req_if.sink       i_req,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output ert_pkg::t_req o_push_req
);
    import ert_pkg::*;

    logic        r_valid;
    t_req        r_req;
    t_req        n_req;
    logic        w_accept;
    logic [29:0] w_half;

    assign i_req.ready = !r_valid || i_push_ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_half      = i_req.stroke_width[30:1];

    always_comb begin
        n_req.center_x  = i_req.center_x;
        n_req.center_y  = i_req.center_y;
        n_req.in_x_neg  = i_req.radius_x < 31'(w_half);
        n_req.in_y_neg  = i_req.radius_y < 31'(w_half);
        n_req.in_x_mag  = n_req.in_x_neg ? 32'(31'(w_half) - i_req.radius_x)
                                         : 32'(i_req.radius_x - 31'(w_half));
        n_req.in_y_mag  = n_req.in_y_neg ? 32'(31'(w_half) - i_req.radius_y)
                                         : 32'(i_req.radius_y - 31'(w_half));
        n_req.out_x_mag = 32'(i_req.radius_x) + 32'(w_half);
        n_req.out_y_mag = 32'(i_req.radius_y) + 32'(w_half);
        n_req.nseg      = (i_req.segment_count > 7'(MAX_SEGMENTS)) ? 7'(MAX_SEGMENTS)
                                                                  : i_req.segment_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            // an empty request is taken and forgotten
            if (w_accept && (i_req.segment_count != 7'd0)) begin
                r_valid <= 1'b1;
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= n_req;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_req   = r_req;

endmodule

>>> hdl/ert_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_fifo
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module ert_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ert_pkg::t_req i_push_req,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ert_pkg::t_req o_pop_req
);
    import ert_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_pop_req    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

>>> hdl/ert_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_back
// Segment sequencer: phase stepping, sine/cosine series and vertex placement
// on one shared multiplier, with an output register.
// ----------------------------------------------------------------------------
module ert_back #(
    parameter int PHASE_BITS = ert_pkg::P_PHASE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  ert_pkg::t_req i_pop_req,
    ert_seg_if.source     o_seg
);
    import ert_pkg::*;

    localparam int CNT_W = $clog2(PHASE_BITS + 1);

    function automatic logic [7:0] f_divisor(input logic is_cos, input logic [3:0] k);
        logic [7:0] d;
        d = 8'd1;
        if (!is_cos) begin
            case (k)
                4'd1:    d = 8'd6;
                4'd2:    d = 8'd20;
                4'd3:    d = 8'd42;
                4'd4:    d = 8'd72;
                4'd5:    d = 8'd110;
                4'd6:    d = 8'd156;
                4'd7:    d = 8'd210;
                default: d = 8'd1;
            endcase
        end else begin
            case (k)
                4'd1:    d = 8'd2;
                4'd2:    d = 8'd12;
                4'd3:    d = 8'd30;
                4'd4:    d = 8'd56;
                4'd5:    d = 8'd90;
                4'd6:    d = 8'd132;
                4'd7:    d = 8'd182;
                4'd8:    d = 8'd240;
                default: d = 8'd1;
            endcase
        end
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] f_recip(input logic is_cos, input logic [3:0] k);
        logic [31:0] r;
        r = 32'd0;
        if (!is_cos) begin
            case (k)
                4'd1:    r = 32'd715827882;
                4'd2:    r = 32'd214748364;
                4'd3:    r = 32'd102261126;
                4'd4:    r = 32'd59652323;
                4'd5:    r = 32'd39045157;
                4'd6:    r = 32'd27531841;
                4'd7:    r = 32'd20452225;
                default: r = 32'd0;
            endcase
        end else begin
            case (k)
                4'd1:    r = 32'd2147483648;
                4'd2:    r = 32'd357913941;
                4'd3:    r = 32'd143165576;
                4'd4:    r = 32'd76695844;
                4'd5:    r = 32'd47721858;
                4'd6:    r = 32'd32537631;
                4'd7:    r = 32'd23598721;
                4'd8:    r = 32'd17895697;
                default: r = 32'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] f_to_q15(input logic signed [33:0] v);
        logic [33:0] c;
        if (v < 0) begin
            c = 34'd0;
        end else if (v > $signed(ONE_Q29)) begin
            c = ONE_Q29;
        end else begin
            c = 34'(v);
        end
        return 16'((c + 34'd8192) >> 14);
    endfunction

    t_bk_state r_state;
    t_bk_state n_state;

    t_req                    r_req;
    logic [CNT_W-1:0]        r_cnt;
    logic [6:0]              r_drem;
    logic [PHASE_BITS:0]     r_q0;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [6:0]              r_prem;
    logic [5:0]              r_seg;
    logic [63:0]             r_prod;
    logic [63:0]             r_xlo;
    logic [31:0]             r_x;
    logic [31:0]             r_x2;
    logic [31:0]             r_term;
    logic [31:0]             r_m;
    logic [31:0]             r_q;
    logic [8:0]              r_rem;
    logic [3:0]              r_k;
    logic                    r_is_cos;
    logic signed [33:0]      r_acc;
    logic signed [33:0]      r_sacc;
    logic [15:0]             r_cmag;
    logic                    r_cneg;
    logic [15:0]             r_smag;
    logic                    r_sneg;
    logic [1:0]              r_p;
    logic signed [31:0]      r_res [4];

    logic                    r_ovalid;
    logic signed [31:0]      r_o_ix;
    logic signed [31:0]      r_o_iy;
    logic signed [31:0]      r_o_ox;
    logic signed [31:0]      r_o_oy;
    logic [6:0]              r_o_ih;
    logic [6:0]              r_o_oh;
    logic [6:0]              r_o_in;
    logic [6:0]              r_o_on;
    logic                    r_o_last;

    logic [31:0]             w_mul_a;
    logic [31:0]             w_mul_b;
    logic [PHASE_BITS-3:0]   w_phase_lo;
    logic [1:0]              w_quad;
    logic [7:0]              w_div_sh;
    logic                    w_div_ge;
    logic [63:0]             w_xsum;
    logic [7:0]              w_d;
    logic [31:0]             w_qd;
    logic [31:0]             w_qf;
    logic signed [33:0]      w_acc_new;
    logic                    w_sin_done;
    logic                    w_cos_done;
    logic [31:0]             w_rad_mag;
    logic                    w_rad_neg;
    logic [15:0]             w_trig_mag;
    logic                    w_trig_neg;
    logic [33:0]             w_pm;
    logic signed [34:0]      w_pv;
    logic signed [31:0]      w_psat;
    logic                    w_slot;
    logic                    w_emit;
    logic                    w_last;
    logic [7:0]              w_psum;
    logic                    w_wrap;
    logic [15:0]             w_c;
    logic [15:0]             w_s;

    assign w_phase_lo = r_phase[PHASE_BITS-3:0];
    assign w_quad     = r_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign w_div_sh   = {1'b0, r_drem} + {1'b0, r_drem} + 8'(r_cnt == CNT_W'(PHASE_BITS));
    assign w_div_ge   = w_div_sh >= {1'b0, r_req.nseg};
    assign w_xsum     = (r_prod << 16) + r_xlo + (64'd1 << PHASE_BITS);
    assign w_d        = f_divisor(r_is_cos, r_k);
    assign w_qd       = 32'(r_prod[63:32] * 32'(w_d));
    assign w_qf       = r_q + 32'(r_rem >= 9'(w_d));
    // odd terms of both series are subtracted
    assign w_acc_new  = r_k[0] ? r_acc - $signed(34'(w_qf)) : r_acc + $signed(34'(w_qf));
    assign w_sin_done = !r_is_cos && (r_k == 4'(SIN_TERMS));
    assign w_cos_done = r_is_cos && (r_k == 4'(COS_TERMS));
    assign w_c        = f_to_q15(r_acc);
    assign w_s        = f_to_q15(r_sacc);
    assign w_last     = (7'(r_seg) + 7'd1) == r_req.nseg;
    assign w_psum     = {1'b0, r_prem} + {1'b0, r_drem};
    assign w_wrap     = w_psum >= {1'b0, r_req.nseg};
    assign w_slot     = !r_ovalid || o_seg.ready;
    assign w_emit     = (r_state == BK_EMIT) && w_slot;

    always_comb begin
        case (r_p)
            2'd0:    begin w_rad_mag = r_req.in_x_mag;  w_rad_neg = r_req.in_x_neg; end
            2'd1:    begin w_rad_mag = r_req.in_y_mag;  w_rad_neg = r_req.in_y_neg; end
            2'd2:    begin w_rad_mag = r_req.out_x_mag; w_rad_neg = 1'b0;           end
            default: begin w_rad_mag = r_req.out_y_mag; w_rad_neg = 1'b0;           end
        endcase
        w_trig_mag = r_p[0] ? r_smag : r_cmag;
        w_trig_neg = r_p[0] ? r_sneg : r_cneg;
    end

    // vertex: centre plus rounded product, saturated to 32 bits
    always_comb begin
        w_pm = 34'((r_prod[47:0] + 48'd16384) >> 15);
        if (w_rad_neg ^ w_trig_neg) begin
            w_pv = 35'(r_p[1] ? r_req.center_x : r_req.center_x) - $signed({1'b0, w_pm});
        end else begin
            w_pv = 35'(r_req.center_x) + $signed({1'b0, w_pm});
        end
        if (r_p[0]) begin
            w_pv = (w_rad_neg ^ w_trig_neg) ? 35'(r_req.center_y) - $signed({1'b0, w_pm})
                                            : 35'(r_req.center_y) + $signed({1'b0, w_pm});
        end
        if (w_pv > 35'sd2147483647) begin
            w_psat = 32'sh7FFF_FFFF;
        end else if (w_pv < -35'sd2147483648) begin
            w_psat = 32'sh8000_0000;
        end else begin
            w_psat = 32'(w_pv);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_pop_valid) n_state = BK_DIV;
            BK_DIV:  if (r_cnt == '0) n_state = BK_SEG;
            BK_SEG:  n_state = BK_XLO;
            BK_XLO:  n_state = BK_XHI;
            BK_XHI:  n_state = BK_XSQ;
            BK_XSQ:  n_state = BK_XSQR;
            BK_XSQR: n_state = BK_TMUL;
            BK_TMUL: n_state = BK_TRND;
            BK_TRND: n_state = BK_TRCP;
            BK_TRCP: n_state = BK_TQ;
            BK_TQ:   n_state = BK_TACC;
            BK_TACC: n_state = w_cos_done ? BK_FOLD : BK_TMUL;
            BK_FOLD: n_state = BK_PMUL;
            BK_PMUL: n_state = BK_PRND;
            BK_PRND: n_state = (r_p == 2'd3) ? BK_EMIT : BK_PMUL;
            BK_EMIT: if (w_slot) n_state = w_last ? BK_IDLE : BK_SEG;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs: queue pop and multiplier operands
    always_comb begin
        o_pop_ready = r_state == BK_IDLE;
        w_mul_a     = 32'd0;
        w_mul_b     = 32'd0;
        case (r_state)
            BK_SEG:  begin w_mul_a = 32'(w_phase_lo); w_mul_b = 32'(PI_HALF_LO); end
            BK_XLO:  begin w_mul_a = 32'(w_phase_lo); w_mul_b = 32'(PI_HALF_HI); end
            BK_XSQ:  begin w_mul_a = r_x;             w_mul_b = r_x;             end
            BK_TMUL: begin w_mul_a = r_term;          w_mul_b = r_x2;            end
            BK_TRCP: begin w_mul_a = r_m;             w_mul_b = f_recip(r_is_cos, r_k); end
            BK_PMUL: begin w_mul_a = w_rad_mag;       w_mul_b = 32'(w_trig_mag); end
            default: begin w_mul_a = 32'd0;           w_mul_b = 32'd0;           end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_seg.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        case (r_state)
            BK_IDLE: begin
                r_req  <= i_pop_req;
                r_cnt  <= CNT_W'(PHASE_BITS);
                r_drem <= 7'd0;
                r_q0   <= '0;
            end
            BK_DIV: begin
                // restoring division of 2^PHASE_BITS by the segment count
                r_drem <= w_div_ge ? 7'(w_div_sh - {1'b0, r_req.nseg}) : 7'(w_div_sh);
                r_q0   <= {r_q0[PHASE_BITS-1:0], w_div_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_phase <= '0;
                r_prem  <= 7'd0;
                r_seg   <= 6'd0;
            end
            BK_XLO: r_xlo <= r_prod;
            BK_XHI: r_x   <= 32'(w_xsum >> (PHASE_BITS + 1));
            BK_XSQR: begin
                r_x2     <= 32'((r_prod + 64'd268435456) >> 29);
                r_term   <= r_x;
                r_acc    <= $signed(34'(r_x));
                r_k      <= 4'd1;
                r_is_cos <= 1'b0;
            end
            BK_TRND: r_m <= 32'((r_prod + 64'd268435456) >> 29);
            BK_TQ: begin
                r_q   <= r_prod[63:32];
                r_rem <= 9'(r_m - w_qd);
            end
            BK_TACC: begin
                if (w_sin_done) begin
                    r_sacc   <= w_acc_new;
                    r_acc    <= $signed(ONE_Q29);
                    r_term   <= 32'(ONE_Q29);
                    r_k      <= 4'd1;
                    r_is_cos <= 1'b1;
                end else begin
                    r_acc  <= w_acc_new;
                    r_term <= w_qf;
                    r_k    <= r_k + 4'd1;
                end
            end
            BK_FOLD: begin
                case (w_quad)
                    2'd0: begin
                        r_cmag <= w_c; r_cneg <= 1'b0; r_smag <= w_s; r_sneg <= 1'b0;
                    end
                    2'd1: begin
                        r_cmag <= w_s; r_cneg <= 1'b1; r_smag <= w_c; r_sneg <= 1'b0;
                    end
                    2'd2: begin
                        r_cmag <= w_c; r_cneg <= 1'b1; r_smag <= w_s; r_sneg <= 1'b1;
                    end
                    default: begin
                        r_cmag <= w_s; r_cneg <= 1'b0; r_smag <= w_c; r_sneg <= 1'b1;
                    end
                endcase
                r_p <= 2'd0;
            end
            BK_PRND: begin
                r_res[r_p] <= w_psat;
                r_p        <= r_p + 2'd1;
            end
            BK_EMIT: begin
                if (w_slot) begin
                    r_seg   <= r_seg + 6'd1;
                    r_prem  <= w_wrap ? 7'(w_psum - {1'b0, r_req.nseg}) : 7'(w_psum);
                    r_phase <= PHASE_BITS'(r_phase + r_q0 + (PHASE_BITS + 1)'(w_wrap));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_ix   <= r_res[0];
            r_o_iy   <= r_res[1];
            r_o_ox   <= r_res[2];
            r_o_oy   <= r_res[3];
            r_o_ih   <= {r_seg, 1'b0};
            r_o_oh   <= {r_seg, 1'b1};
            r_o_in   <= w_last ? 7'd0 : {6'(r_seg + 6'd1), 1'b0};
            r_o_on   <= w_last ? 7'd1 : {6'(r_seg + 6'd1), 1'b1};
            r_o_last <= w_last;
        end
    end

    assign o_seg.valid            = r_ovalid;
    assign o_seg.inner_x          = r_o_ix;
    assign o_seg.inner_y          = r_o_iy;
    assign o_seg.outer_x          = r_o_ox;
    assign o_seg.outer_y          = r_o_oy;
    assign o_seg.inner_here_index = r_o_ih;
    assign o_seg.outer_here_index = r_o_oh;
    assign o_seg.inner_next_index = r_o_in;
    assign o_seg.outer_next_index = r_o_on;
    assign o_seg.last_segment     = r_o_last;

endmodule
